// ===== hdl/wkb_geometry_byte_parser_top_defines.svh =====
// assertion macros for the wkb geometry byte parser
`ifndef WKB_GEOMETRY_BYTE_PARSER_TOP_DEFINES_SVH
`define WKB_GEOMETRY_BYTE_PARSER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define WKB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wkb parser assertion failed");
// condition must never be seen outside reset
`define WKB_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("wkb parser forbidden condition seen");
`else
`define WKB_ASSERT(label, clk, rst_n, prop)
`define WKB_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hdl/wkb_pkg.sv =====
package wkb_pkg;

  // default width of ring and point counters
  localparam int COUNT_BITS_DEF = 32;

  // geometry kinds held in the config register, none rejects every type word
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;
  localparam logic [1:0] KIND_POLY  = 2'd3;

  // result kinds carried on tuser
  localparam logic RES_VERTEX = 1'b0;
  localparam logic RES_ERROR  = 1'b1;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_ORDER = 3'd1,
    ERR_TYPE  = 3'd2,
    ERR_COUNT = 3'd3,
    ERR_TRUNC = 3'd4
  } err_e;

  // control from the phase machine to the word assembler
  typedef struct packed {
    logic word_phase;  // phase collects a multi-byte word
    logic wide;        // word is 64 bits, else 32 bits
  } asm_ctrl_t;

  // status from the word assembler
  typedef struct packed {
    logic        done;  // current byte completes the word
    logic [63:0] word;  // word including the current byte
  } asm_stat_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic [31:0] ring_number;
    logic [31:0] vertex_number;
    logic        ring_done;
    logic        geometry_done;
    err_e        error_code;
  } res_t;

endpackage

// ===== hdl/wkb_geometry_byte_parser_top.sv =====
// channel    dir  tdata                                       tuser        tlast
// s_axis     in   [7:0] data_byte                             -            blob_end
// m_axis     out  [63:0] x, [127:64] y, [159:128] ring,       result_kind  geometry_done
//                 [191:160] vertex, [192] ring_done,
//                 [195:193] error_code, [199:196] zero
// cfg        in   [1:0] expected_kind, written when cfg_valid_i and cfg_ready_o
//
// one byte per cycle with s_axis_tready high; each byte passes the phase machine
// and word assembler combinationally and any result is registered in a one-entry
// output stage; results appear on m_axis in the cycle after the causing byte transfer
// s_axis_tready drops only while the output stage is full and m_axis_tready is low
// reset is asynchronous, active low; the parser waits for a byte-order byte
`include "wkb_geometry_byte_parser_top_defines.svh"

module wkb_geometry_byte_parser_top #(
  parameter int COUNT_BITS = wkb_pkg::COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,   // x_bits, y_bits, ring_number, vertex_number,
                                       // ring_done, error_code
  output logic         m_axis_tuser,   // result_kind
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i
);

  logic               accept;
  logic [1:0]         kind_q;
  wkb_pkg::asm_ctrl_t asm_ctrl;
  wkb_pkg::asm_stat_t asm_stat;
  logic               res_valid;
  wkb_pkg::res_t      res;
  wkb_pkg::res_t      out_res;
  logic               space;
  logic               out_err;
  logic               out_vtx;

  // byte transfer
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = space;

  // expected kind register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= wkb_pkg::KIND_POINT;
    end else if (cfg_valid_i) begin
      kind_q <= cfg_data_i;
    end
  end

  wkb_asm u_asm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .ctrl_i   (asm_ctrl),
    .stat_o   (asm_stat)
  );

  wkb_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .kind_i      (kind_q),
    .asm_i       (asm_stat),
    .asm_o       (asm_ctrl),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wkb_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res),
    .space_o (space)
  );

  // result packing
  assign m_axis_tdata = {4'b0000, out_res.error_code, out_res.ring_done,
                         out_res.vertex_number, out_res.ring_number,
                         out_res.y_bits, out_res.x_bits};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.geometry_done;

  // result consistency checks
  assign out_err = m_axis_tvalid && (out_res.kind == wkb_pkg::RES_ERROR);
  assign out_vtx = m_axis_tvalid && (out_res.kind == wkb_pkg::RES_VERTEX);

  `WKB_ASSERT(a_err_has_code, clk_i, rst_ni, out_err |-> out_res.error_code != wkb_pkg::ERR_NONE)
  `WKB_ASSERT(a_err_no_vertex, clk_i, rst_ni, out_err |-> !(m_axis_tlast || out_res.ring_done))
  `WKB_ASSERT(a_vtx_no_code, clk_i, rst_ni, out_vtx |-> out_res.error_code == wkb_pkg::ERR_NONE)
  `WKB_ASSERT_NEVER(a_geo_ring, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast && !out_res.ring_done)

endmodule

// ===== hdl/wkb_asm.sv =====
module wkb_asm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  wkb_pkg::asm_ctrl_t  ctrl_i,
  output wkb_pkg::asm_stat_t  stat_o
);

  localparam logic [2:0] PosLastWide   = 3'd7;
  localparam logic [2:0] PosLastNarrow = 3'd3;

  logic [2:0]  pos_q, pos_d;
  logic [63:0] word_q, word_d;
  logic [63:0] word_full;
  logic        done;

  // little-endian merge of the current byte
  always_comb begin
    word_full = word_q | (64'(byte_i) << {pos_q, 3'b000});
    done      = ctrl_i.word_phase &&
                (pos_q == (ctrl_i.wide ? PosLastWide : PosLastNarrow));
    stat_o.done = done;
    stat_o.word = word_full;
  end

  // byte position and partial word
  always_comb begin
    pos_d  = pos_q;
    word_d = word_q;
    if (accept_i) begin
      if (!ctrl_i.word_phase || done || last_i) begin
        pos_d  = '0;
        word_d = '0;
      end else begin
        pos_d  = pos_q + 3'd1;
        word_d = word_full;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      word_q <= '0;
    end else begin
      pos_q  <= pos_d;
      word_q <= word_d;
    end
  end

endmodule

// ===== hdl/wkb_fsm.sv =====
module wkb_fsm #(
  parameter int COUNT_BITS = wkb_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  logic [1:0]         kind_i,
  input  wkb_pkg::asm_stat_t asm_i,
  output wkb_pkg::asm_ctrl_t asm_o,
  output logic               res_valid_o,
  output wkb_pkg::res_t      res_o
);

  typedef enum logic [2:0] {
    PH_ORDER,
    PH_TYPE,
    PH_RCOUNT,
    PH_PCOUNT,
    PH_X,
    PH_Y,
    PH_SKIP
  } phase_e;

  localparam logic [7:0]  OrderLittle = 8'h01;
  localparam logic [31:0] CountMax    = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  phase_e                phase_q, phase_d;
  logic [63:0]           held_x_q, held_x_d;
  logic [COUNT_BITS-1:0] rings_q, rings_d;
  logic [COUNT_BITS-1:0] points_q, points_d;
  logic [COUNT_BITS-1:0] ring_q, ring_d;
  logic [COUNT_BITS-1:0] vtx_q, vtx_d;

  logic [31:0]           cnt_w;
  logic [COUNT_BITS-1:0] cnt_sat;
  wkb_pkg::err_e         err;
  logic                  vtx;
  logic                  rdone;
  logic                  gdone;

  // assembler control follows the phase
  always_comb begin
    asm_o.word_phase = (phase_q != PH_ORDER) && (phase_q != PH_SKIP);
    asm_o.wide       = (phase_q == PH_X) || (phase_q == PH_Y);
  end

  // saturated count from the assembled word
  always_comb begin
    cnt_w   = asm_i.word[31:0];
    cnt_sat = (cnt_w > CountMax) ? CountMax[COUNT_BITS-1:0] : cnt_w[COUNT_BITS-1:0];
  end

  // phase machine and result build
  always_comb begin
    phase_d  = phase_q;
    held_x_d = held_x_q;
    rings_d  = rings_q;
    points_d = points_q;
    ring_d   = ring_q;
    vtx_d    = vtx_q;
    err      = wkb_pkg::ERR_NONE;
    vtx      = 1'b0;
    rdone    = points_q <= CntOne;
    gdone    = 1'b0;
    res_valid_o = 1'b0;

    if (accept_i) begin
      case (phase_q)
        PH_SKIP: begin
          if (last_i) phase_d = PH_ORDER;
        end
        PH_ORDER: begin
          if (byte_i != OrderLittle) err = wkb_pkg::ERR_ORDER;
          else phase_d = PH_TYPE;
        end
        default: begin
          if (asm_i.done) begin
            case (phase_q)
              PH_TYPE: begin
                if (kind_i == wkb_pkg::KIND_NONE || cnt_w != {30'd0, kind_i}) begin
                  err = wkb_pkg::ERR_TYPE;
                end else if (kind_i == wkb_pkg::KIND_POINT) begin
                  rings_d  = CntOne;
                  points_d = CntOne;
                  ring_d   = '0;
                  vtx_d    = '0;
                  phase_d  = PH_X;
                end else if (kind_i == wkb_pkg::KIND_LINE) begin
                  rings_d = CntOne;
                  ring_d  = '0;
                  phase_d = PH_PCOUNT;
                end else begin
                  phase_d = PH_RCOUNT;
                end
              end
              PH_RCOUNT: begin
                if (cnt_w == 32'd0) begin
                  err = wkb_pkg::ERR_COUNT;
                end else begin
                  rings_d = cnt_sat;
                  ring_d  = '0;
                  phase_d = PH_PCOUNT;
                end
              end
              PH_PCOUNT: begin
                if (cnt_w == 32'd0) begin
                  err = wkb_pkg::ERR_COUNT;
                end else begin
                  points_d = cnt_sat;
                  vtx_d    = '0;
                  phase_d  = PH_X;
                end
              end
              PH_X: begin
                held_x_d = asm_i.word;
                phase_d  = PH_Y;
              end
              default: begin
                // y word completes a vertex
                vtx   = 1'b1;
                gdone = rdone && (rings_q <= CntOne);
                if (gdone) begin
                  phase_d = phase_q;
                end else if (rdone) begin
                  rings_d = rings_q - CntOne;
                  ring_d  = ring_q + CntOne;
                  vtx_d   = '0;
                  phase_d = PH_PCOUNT;
                end else begin
                  points_d = points_q - CntOne;
                  vtx_d    = vtx_q + CntOne;
                  phase_d  = PH_X;
                end
              end
            endcase
          end
        end
      endcase

      // outcome of the byte
      if (phase_q != PH_SKIP) begin
        if (err != wkb_pkg::ERR_NONE) begin
          res_valid_o = 1'b1;
          phase_d     = last_i ? PH_ORDER : PH_SKIP;
        end else if (vtx && gdone) begin
          res_valid_o = 1'b1;
          phase_d     = last_i ? PH_ORDER : PH_SKIP;
        end else if (last_i) begin
          err         = wkb_pkg::ERR_TRUNC;
          res_valid_o = 1'b1;
          phase_d     = PH_ORDER;
        end else begin
          res_valid_o = vtx;
        end
      end
    end

    // result payload
    if (err != wkb_pkg::ERR_NONE) begin
      res_o               = '0;
      res_o.kind          = wkb_pkg::RES_ERROR;
      res_o.error_code    = err;
    end else begin
      res_o.kind          = wkb_pkg::RES_VERTEX;
      res_o.x_bits        = held_x_q;
      res_o.y_bits        = asm_i.word;
      res_o.ring_number   = 32'(ring_q);
      res_o.vertex_number = 32'(vtx_q);
      res_o.ring_done     = rdone;
      res_o.geometry_done = gdone;
      res_o.error_code    = wkb_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ORDER;
      held_x_q <= '0;
      rings_q  <= '0;
      points_q <= '0;
      ring_q   <= '0;
      vtx_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      held_x_q <= held_x_d;
      rings_q  <= rings_d;
      points_q <= points_d;
      ring_q   <= ring_d;
      vtx_q    <= vtx_d;
    end
  end

endmodule

// ===== hdl/wkb_obuf.sv =====
module wkb_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  wkb_pkg::res_t res_i,
  input  logic          ready_i,
  output logic          valid_o,
  output wkb_pkg::res_t res_o,
  output logic          space_o
);

  logic          valid_q, valid_d;
  wkb_pkg::res_t res_q, res_d;

  // room for a new result when empty or draining this cycle
  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
